@@ src/range_add_range_sum_tree_top_defines.svh @@
// Assertion macros shared by the range add / range sum tree RTL.
// No dependencies; include in module bodies that assert.
`ifndef RANGE_ADD_RANGE_SUM_TREE_TOP_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_TREE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RARS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RARS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rars_pkg.sv @@
// Package for the range add / range sum tree: widths, codes and node type.
// No dependencies.
package rars_pkg;

  localparam int unsigned MaxPositionsDef = 1024;
  localparam int unsigned CfgW = 11;
  localparam int unsigned PosW = 11;
  localparam int unsigned AmtW = 16;
  localparam int unsigned SumW = 64;

  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic [SumW-1:0] total;
    logic [SumW-1:0] pending;
  } node_t;

  typedef enum logic [1:0] {
    GiveSelf  = 2'd0,
    GiveLeft  = 2'd1,
    GiveRight = 2'd2
  } give_sel_e;

endpackage

@@ src/rars_mem.sv @@
// Node store: one write port, one read port, registered read data.
// Depends on rars_pkg for node_t.
module rars_mem
  import rars_pkg::*;
#(
  parameter int unsigned Depth = 2 * MaxPositionsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  node_t                    wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output node_t                    rdata_o
);

  node_t mem_q [Depth];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rars_ctrl.sv @@
// Traversal sequencer: walks the tree with an explicit stack, read-modify-write
// of nodes in rars_mem, clearing pass. Depends on rars_pkg and the defines header.
module rars_ctrl
  import rars_pkg::*;
#(
  parameter int unsigned MaxPositions = MaxPositionsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   op_i,
  input  logic [PosW-1:0]        lq_i,
  input  logic [PosW-1:0]        rq_i,
  input  logic signed [AmtW-1:0] amount_i,
  input  logic                   cfg_we_i,
  input  logic [CfgW-1:0]        cfg_i,
  output logic                   res_valid_o,
  output logic [SumW-1:0]        res_o,
  output logic                   mem_we_o,
  output logic [$clog2(2*MaxPositions)-1:0] mem_waddr_o,
  output node_t                  mem_wdata_o,
  output logic                   mem_re_o,
  output logic [$clog2(2*MaxPositions)-1:0] mem_raddr_o,
  input  node_t                  mem_rdata_i
);

  `include "range_add_range_sum_tree_top_defines.svh"

  localparam int unsigned NodeCount = 2 * MaxPositions;
  localparam int unsigned AW  = $clog2(NodeCount);
  localparam int unsigned PW  = $clog2(MaxPositions + 1);
  localparam int unsigned CW  = (PW > PosW) ? PW : PosW;
  localparam int unsigned SD  = $clog2(MaxPositions) + 1;
  localparam int unsigned SPW = $clog2(SD + 1);
  localparam int unsigned IW  = (SD > 1) ? $clog2(SD) : 1;
  localparam logic [AW-1:0] LastNode = AW'(NodeCount - 1);
  localparam logic [CW-1:0] MaxN = CW'(MaxPositions);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_VISIT   = 16'h0004,
    S_HD_RD   = 16'h0008,
    S_HD_WAIT = 16'h0010,
    S_DESCEND = 16'h0020,
    S_GV_RD   = 16'h0040,
    S_GV_WAIT = 16'h0080,
    S_GV_WR   = 16'h0100,
    S_CLR_PND = 16'h0200,
    S_Q_RD    = 16'h0400,
    S_Q_WAIT  = 16'h0800,
    S_RET     = 16'h1000,
    S_SUM_RDL = 16'h2000,
    S_SUM_RDR = 16'h4000,
    S_SUM_WR  = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CfgW-1:0] cfg_q, cfg_d;
  logic op_q, op_d;
  logic [CW-1:0] lq_q, lq_d, rq_q, rq_d;
  logic [SumW-1:0] x_q, x_d;
  logic [AW-1:0] id_q, id_d;
  logic [CW-1:0] lb_q, lb_d, rb_q, rb_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [AW-1:0] give_id_q, give_id_d;
  logic [CW-1:0] give_len_q, give_len_d;
  logic [SumW-1:0] give_amt_q, give_amt_d;
  give_sel_e give_sel_q, give_sel_d;
  node_t node_q, node_d;
  logic [SumW-1:0] prod_q, prod_d;
  logic [SumW-1:0] acc_q, acc_d;
  logic [SumW-1:0] owed_q, owed_d;
  logic [SumW-1:0] par_total_q, par_total_d;
  logic [SumW-1:0] lsum_q, lsum_d;
  logic res_valid_q, res_valid_d;
  logic [SumW-1:0] res_q, res_d;

  logic [AW-1:0] stk_id_q [SD];
  logic [CW-1:0] stk_lb_q [SD];
  logic [CW-1:0] stk_rb_q [SD];
  logic          stk_ph_q [SD];
  logic push, set_ph;

  logic [CW-1:0] size_n, mid, hi_l, lo_r;
  logic [CW:0]   lbrb;
  logic [AW-1:0] left_id, right_id;
  logic covered, skip;
  logic [SPW-1:0] sp_m1;
  logic [IW-1:0]  top;
  logic [CW-1:0]  t_mid;
  logic [CW:0]    t_sum;
  logic [SumW-1:0] hi_part;

  always_comb begin
    if (cfg_q == '0) begin
      size_n = CW'(1);
    end else if (CW'(cfg_q) > MaxN) begin
      size_n = MaxN;
    end else begin
      size_n = CW'(cfg_q);
    end
  end

  assign lbrb     = {1'b0, lb_q} + {1'b0, rb_q};
  assign mid      = lbrb[CW:1];
  assign left_id  = id_q + AW'(1);
  assign right_id = id_q + AW'({mid - lb_q, 1'b0});
  assign hi_l     = (lb_q > lq_q) ? lb_q : lq_q;
  assign lo_r     = (rb_q < rq_q) ? rb_q : rq_q;
  assign covered  = (lb_q >= lq_q) && (rb_q <= rq_q);
  assign skip     = (hi_l >= lo_r) || ((rb_q - lb_q) < CW'(2));
  assign sp_m1    = sp_q - SPW'(1);
  assign top      = sp_m1[IW-1:0];
  assign t_sum    = {1'b0, stk_lb_q[top]} + {1'b0, stk_rb_q[top]};
  assign t_mid    = t_sum[CW:1];
  assign hi_part  = {32'(give_amt_q[63:32] * give_len_q), 32'd0};

  always_comb begin
    state_d = state_q;   clr_d = clr_q;     cfg_d = cfg_q;
    op_d = op_q;         lq_d = lq_q;       rq_d = rq_q;       x_d = x_q;
    id_d = id_q;         lb_d = lb_q;       rb_d = rb_q;       sp_d = sp_q;
    give_id_d = give_id_q; give_len_d = give_len_q; give_amt_d = give_amt_q;
    give_sel_d = give_sel_q; node_d = node_q; prod_d = prod_q;
    acc_d = acc_q;       owed_d = owed_q;   par_total_d = par_total_q;
    lsum_d = lsum_q;     res_valid_d = 1'b0; res_d = res_q;
    push = 1'b0;         set_ph = 1'b0;
    mem_we_o = 1'b0;     mem_waddr_o = id_q; mem_wdata_o = '0;
    mem_re_o = 1'b0;     mem_raddr_o = id_q;
    case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
        mem_waddr_o = clr_q;
        if (cfg_we_i) begin
          // A size write during the pass restarts it.
          cfg_d = cfg_i;
          clr_d = '0;
        end else if (clr_q == LastNode) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cfg_we_i) begin
          cfg_d = cfg_i;
          clr_d = '0;
          state_d = S_CLEAR;
        end else if (start_i) begin
          op_d = op_i;
          lq_d = CW'(lq_i);
          rq_d = CW'(rq_i);
          x_d = SumW'(amount_i);
          id_d = '0;
          lb_d = '0;
          rb_d = size_n;
          sp_d = '0;
          acc_d = '0;
          state_d = S_VISIT;
        end
      end
      S_VISIT: begin
        if (covered) begin
          if (op_q == OpAdd) begin
            give_id_d = id_q;
            give_len_d = rb_q - lb_q;
            give_amt_d = x_q;
            give_sel_d = GiveSelf;
            state_d = S_GV_RD;
          end else begin
            state_d = S_Q_RD;
          end
        end else if (skip) begin
          state_d = S_RET;
        end else begin
          state_d = S_HD_RD;
        end
      end
      S_HD_RD: begin
        mem_re_o = 1'b1;
        state_d = S_HD_WAIT;
      end
      S_HD_WAIT: begin
        par_total_d = mem_rdata_i.total;
        if (mem_rdata_i.pending != '0) begin
          owed_d = mem_rdata_i.pending;
          give_id_d = left_id;
          give_len_d = mid - lb_q;
          give_amt_d = mem_rdata_i.pending;
          give_sel_d = GiveLeft;
          state_d = S_GV_RD;
        end else begin
          state_d = S_DESCEND;
        end
      end
      S_DESCEND: begin
        push = 1'b1;
        id_d = left_id;
        rb_d = mid;
        sp_d = sp_q + SPW'(1);
        state_d = S_VISIT;
      end
      S_GV_RD: begin
        mem_re_o = 1'b1;
        mem_raddr_o = give_id_q;
        state_d = S_GV_WAIT;
      end
      S_GV_WAIT: begin
        node_d = mem_rdata_i;
        prod_d = SumW'(give_amt_q[31:0] * give_len_q);
        state_d = S_GV_WR;
      end
      S_GV_WR: begin
        mem_we_o = 1'b1;
        mem_waddr_o = give_id_q;
        mem_wdata_o.total = node_q.total + prod_q + hi_part;
        mem_wdata_o.pending = (give_len_q > CW'(1)) ? node_q.pending + give_amt_q
                                                     : node_q.pending;
        case (give_sel_q)
          GiveLeft: begin
            give_id_d = right_id;
            give_len_d = rb_q - mid;
            give_amt_d = owed_q;
            give_sel_d = GiveRight;
            state_d = S_GV_RD;
          end
          GiveRight: state_d = S_CLR_PND;
          default:   state_d = S_RET;
        endcase
      end
      S_CLR_PND: begin
        mem_we_o = 1'b1;
        mem_wdata_o.total = par_total_q;
        state_d = S_DESCEND;
      end
      S_Q_RD: begin
        mem_re_o = 1'b1;
        state_d = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        acc_d = acc_q + mem_rdata_i.total;
        state_d = S_RET;
      end
      S_RET: begin
        if (sp_q == '0) begin
          res_valid_d = (op_q == OpQuery);
          res_d = acc_q;
          state_d = S_IDLE;
        end else if (!stk_ph_q[top]) begin
          // Left subtree finished: take the right child next.
          set_ph = 1'b1;
          id_d = stk_id_q[top] + AW'({t_mid - stk_lb_q[top], 1'b0});
          lb_d = t_mid;
          rb_d = stk_rb_q[top];
          state_d = S_VISIT;
        end else begin
          id_d = stk_id_q[top];
          lb_d = stk_lb_q[top];
          rb_d = stk_rb_q[top];
          sp_d = sp_m1;
          state_d = (op_q == OpAdd) ? S_SUM_RDL : S_RET;
        end
      end
      S_SUM_RDL: begin
        mem_re_o = 1'b1;
        mem_raddr_o = left_id;
        state_d = S_SUM_RDR;
      end
      S_SUM_RDR: begin
        lsum_d = mem_rdata_i.total;
        mem_re_o = 1'b1;
        mem_raddr_o = right_id;
        state_d = S_SUM_WR;
      end
      S_SUM_WR: begin
        mem_we_o = 1'b1;
        mem_wdata_o.total = lsum_q + mem_rdata_i.total;
        state_d = S_RET;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      cfg_q <= CfgReset;
      sp_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cfg_q <= cfg_d;
      sp_q <= sp_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;       lq_q <= lq_d;       rq_q <= rq_d;       x_q <= x_d;
    id_q <= id_d;       lb_q <= lb_d;       rb_q <= rb_d;
    give_id_q <= give_id_d; give_len_q <= give_len_d; give_amt_q <= give_amt_d;
    give_sel_q <= give_sel_d; node_q <= node_d; prod_q <= prod_d;
    acc_q <= acc_d;     owed_q <= owed_d;   par_total_q <= par_total_d;
    lsum_q <= lsum_d;   res_q <= res_d;
    if (push) begin
      stk_id_q[sp_q[IW-1:0]] <= id_q;
      stk_lb_q[sp_q[IW-1:0]] <= lb_q;
      stk_rb_q[sp_q[IW-1:0]] <= rb_q;
      stk_ph_q[sp_q[IW-1:0]] <= 1'b0;
    end else if (set_ph) begin
      stk_ph_q[top] <= 1'b1;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `RARS_ASSERT_IMPL(a_res_query, res_valid_q, op_q == OpQuery, "result beat from an add")
  `RARS_ASSERT_IMPL(a_idle_no_wr, state_q == S_IDLE, !mem_we_o, "node write while idle")
  `RARS_ASSERT_NEXT(a_start_root, (state_q == S_IDLE) && start_i && !cfg_we_i,
                    (sp_q == '0) && (state_q == S_VISIT), "item did not start at the root")
  `RARS_ASSERT_IMPL(a_clear_busy, state_q == S_CLEAR, busy_o && !res_valid_d,
                    "clearing pass not busy")

endmodule

@@ src/range_add_range_sum_tree_top.sv @@
// Busy stays high while an item walks the tree node by node, its length set by the node
// reads and read-modify-writes; a pending add at a split node is handed to both children.
// One item at a time; a query's result beat shows in the first cycle busy is low.
// Reset and each size write taken while idle or clearing run a clearing pass
// over all 2*MAX_POSITIONS nodes with busy high; reset size is 1024 positions.
// The receiver cannot stall.
module range_add_range_sum_tree_top
  import rars_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MaxPositionsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation_i,
  input  logic [PosW-1:0]        range_start_i,
  input  logic [PosW-1:0]        range_end_i,
  input  logic signed [AmtW-1:0] amount_i,
  input  logic                   positions_in_use_we_i,
  input  logic [CfgW-1:0]        positions_in_use_i,
  output logic                   range_total_valid_o,
  output logic signed [SumW-1:0] range_total_o
);

  localparam int unsigned NodeCount = 2 * MAX_POSITIONS;
  localparam int unsigned AW = $clog2(NodeCount);

  // Node store port signals: one write and one read per cycle.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  node_t         mem_wdata, mem_rdata;
  logic [SumW-1:0] res;

  // Sequencer: one node visit at a time, read, modify, write back; every
  // access waits for the one before, so overlapping accesses never occur.
  rars_ctrl #(
    .MaxPositions(MAX_POSITIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .op_i        (operation_i),
    .lq_i        (range_start_i),
    .rq_i        (range_end_i),
    .amount_i    (amount_i),
    .cfg_we_i    (positions_in_use_we_i),
    .cfg_i       (positions_in_use_i),
    .res_valid_o (range_total_valid_o),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Node store: sum and pending add per node, preorder numbering.
  rars_mem #(
    .Depth(NodeCount)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign range_total_o = $signed(res);

endmodule
